>>> design/zrht_pkg.sv
// ----------------------------------------------------------------------------
// zrht_pkg
// Shared types and codes for the z-ordered rectangle hit table.
// ----------------------------------------------------------------------------
package zrht_pkg;

	localparam int ZRHT_MAX_TILES = 16;

	typedef enum logic [3:0] {
		CMD_ADD_BACK   = 4'd0,
		CMD_ADD_FRONT  = 4'd1,
		CMD_CLEAR      = 4'd2,
		CMD_HIGHLIGHT  = 4'd3,
		CMD_RAISE      = 4'd4,
		CMD_LOWER      = 4'd5,
		CMD_REMOVE     = 4'd6,
		CMD_REMOVE_ALL = 4'd7,
		CMD_MERGE      = 4'd8,
		CMD_READ       = 4'd9
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2,
		STAT_NONE = 2'd3
	} status_t;

	// x in the low bits, color on top
	typedef struct packed {
		logic [7:0]  c;
		logic [11:0] h;
		logic [11:0] w;
		logic [11:0] y;
		logic [11:0] x;
	} tile_t;

	localparam int TILE_W = $bits(tile_t);

	// bounding box, right and bottom edges exclusive, 13 bits so nothing wraps
	typedef struct packed {
		logic [11:0] l;
		logic [11:0] t;
		logic [12:0] r;
		logic [12:0] b;
	} bbox_t;

endpackage

>>> design/zrht_ram.sv
// ----------------------------------------------------------------------------
// zrht_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module zrht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/zrht_hit.sv
// ----------------------------------------------------------------------------
// zrht_hit
// Shared compare unit: half-open point containment and bounding box growth.
// ----------------------------------------------------------------------------
module zrht_hit (
	input  zrht_pkg::tile_t tile,
	input  logic [11:0]     px,
	input  logic [11:0]     py,
	input  zrht_pkg::bbox_t box_in,
	output logic            hit,
	output zrht_pkg::bbox_t box_out
);
	import zrht_pkg::*;

	logic [12:0] right, bottom;

	assign right  = {1'b0, tile.x} + {1'b0, tile.w};
	assign bottom = {1'b0, tile.y} + {1'b0, tile.h};

	assign hit = (tile.x <= px) && ({1'b0, px} < right) &&
		(tile.y <= py) && ({1'b0, py} < bottom);

	always_comb begin
		box_out.l = (tile.x < box_in.l) ? tile.x : box_in.l;
		box_out.t = (tile.y < box_in.t) ? tile.y : box_in.t;
		box_out.r = (right > box_in.r) ? right : box_in.r;
		box_out.b = (bottom > box_in.b) ? bottom : box_in.b;
	end

endmodule

>>> design/zorder_rect_hit_table_top.sv
// ----------------------------------------------------------------------------
// zorder_rect_hit_table_top
// Front-to-back ordered rectangle table with point hit commands.
//
// channel  dir  handshake                     content
// s_axis   in   s_axis_tvalid/s_axis_tready   one command transaction
// m_axis   out  m_axis_tvalid/m_axis_tready   one result transaction
// cfg      in   cfg_valid/cfg_ready           highlight color
//
// A command runs through at most a scan for the first hit, a compaction pass
// and a shift-up pass over the stored tiles, one entry per cycle through the
// tile RAM and the shared compare unit.
// Input is taken only while idle; a held result stalls the next command in
// its output state.
// arst_n clears the tile count and the state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module zorder_rect_hit_table_top #(
	parameter int MAX_TILES = zrht_pkg::ZRHT_MAX_TILES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// px, py, width, height, color, position, pad
	input  logic [63:0] s_axis_tdata,
	// cmd
	input  logic [3:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// removed, tile_x, tile_y, tile_width, tile_height, tile_color, occupancy, pad
	output logic [71:0] m_axis_tdata,
	// status
	output logic [1:0]  m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import zrht_pkg::*;

	localparam int IW = $clog2(MAX_TILES);
	localparam int CW = $clog2(MAX_TILES + 1);
	localparam int PW = (CW > 4) ? CW : 4;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_RDW     = 7'b0000010,
		ST_SCAN    = 7'b0000100,
		ST_COMPACT = 7'b0001000,
		ST_SHIFT   = 7'b0010000,
		ST_FINAL   = 7'b0100000,
		ST_OUT     = 7'b1000000
	} state_t;

	state_t          st_q;
	logic [3:0]      cmd_q;
	logic [11:0]     px_q, py_q;
	tile_t           nt_q, res_q;
	logic            pos_ok_q;
	logic [CW-1:0]   count_q, rd_q, wr_q, i_q, removed_q;
	logic [IW-1:0]   pa_q, hit_q;
	logic            pend_q;
	bbox_t           bbox_q;
	status_t         status_q;
	logic [7:0]      hl_q;

	logic [11:0] in_px, in_py, in_w, in_h;
	logic [7:0]  in_color;
	logic [3:0]  in_pos, in_cmd;
	logic        s_fire, out_load, drop, rd_more;
	logic [PW-1:0] pos_ext, cnt_ext;

	logic            we;
	logic [IW-1:0]   waddr, raddr;
	tile_t           wdata, rd_tile;
	logic [TILE_W-1:0] rdata;

	logic  hit;
	bbox_t box_in, box_out;
	logic [12:0] dw, dh;
	tile_t merged;

	assign in_px    = s_axis_tdata[11:0];
	assign in_py    = s_axis_tdata[23:12];
	assign in_w     = s_axis_tdata[35:24];
	assign in_h     = s_axis_tdata[47:36];
	assign in_color = s_axis_tdata[55:48];
	assign in_pos   = s_axis_tdata[59:56];
	assign in_cmd   = s_axis_tuser;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign out_load      = (st_q == ST_OUT) && (!m_axis_tvalid || m_axis_tready);
	assign pos_ext       = PW'(in_pos);
	assign cnt_ext       = PW'(count_q);
	assign rd_more       = (rd_q < count_q);
	assign rd_tile       = tile_t'(rdata);

	assign box_in = (st_q == ST_SCAN) ? '{l: 12'hFFF, t: 12'hFFF, r: '0, b: '0} : bbox_q;

	zrht_hit u_hit (
		.tile    (rd_tile),
		.px      (px_q),
		.py      (py_q),
		.box_in  (box_in),
		.hit     (hit),
		.box_out (box_out)
	);

	assign drop = pend_q && hit &&
		((cmd_q == CMD_REMOVE_ALL) || (cmd_q == CMD_MERGE));

	assign dw = bbox_q.r - {1'b0, bbox_q.l};
	assign dh = bbox_q.b - {1'b0, bbox_q.t};
	always_comb begin
		merged   = res_q;
		merged.x = bbox_q.l;
		merged.y = bbox_q.t;
		merged.w = (dw > 13'd4095) ? 12'hFFF : dw[11:0];
		merged.h = (dh > 13'd4095) ? 12'hFFF : dh[11:0];
	end

	zrht_ram #(
		.WIDTH (TILE_W),
		.DEPTH (MAX_TILES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = rd_tile;
		raddr = rd_q[IW-1:0];
		case (st_q)
			ST_IDLE: begin
				raddr = IW'(in_pos);
			end
			ST_COMPACT: begin
				we    = pend_q && !drop;
				waddr = wr_q[IW-1:0];
			end
			ST_SHIFT: begin
				raddr = IW'(i_q - CW'(1));
				we    = pend_q;
				waddr = pa_q + IW'(1);
			end
			ST_FINAL: begin
				case (cmd_q)
					CMD_ADD_BACK: begin
						we    = 1'b1;
						waddr = count_q[IW-1:0];
						wdata = nt_q;
					end
					CMD_ADD_FRONT: begin
						we    = 1'b1;
						wdata = nt_q;
					end
					CMD_HIGHLIGHT: begin
						we      = 1'b1;
						waddr   = hit_q;
						wdata   = res_q;
						wdata.c = hl_q;
					end
					CMD_RAISE, CMD_MERGE: begin
						we    = 1'b1;
						wdata = res_q;
					end
					CMD_LOWER: begin
						we    = 1'b1;
						waddr = count_q[IW-1:0];
						wdata = res_q;
					end
					default: begin
						we = 1'b0;
					end
				endcase
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hl_q <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			hl_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (s_fire) begin
						cmd_q     <= in_cmd;
						px_q      <= in_px;
						py_q      <= in_py;
						nt_q      <= '{c: in_color, h: in_h, w: in_w, y: in_py, x: in_px};
						res_q     <= '0;
						status_q  <= STAT_OK;
						removed_q <= '0;
						pend_q    <= 1'b0;
						rd_q      <= '0;
						pos_ok_q  <= (pos_ext < cnt_ext);
						i_q       <= count_q;
						if (in_cmd inside {CMD_ADD_BACK, CMD_ADD_FRONT}) begin
							if (count_q >= CW'(MAX_TILES)) begin
								status_q <= STAT_FULL;
								st_q     <= ST_OUT;
							end else if (in_cmd == CMD_ADD_FRONT) begin
								st_q <= ST_SHIFT;
							end else begin
								st_q <= ST_FINAL;
							end
						end else if (in_cmd == CMD_CLEAR) begin
							count_q <= '0;
							st_q    <= ST_OUT;
						end else if (in_cmd inside {[CMD_HIGHLIGHT:CMD_MERGE]}) begin
							st_q <= ST_SCAN;
						end else if (in_cmd == CMD_READ) begin
							st_q <= ST_RDW;
						end else begin
							st_q <= ST_OUT;
						end
					end
				end
				ST_RDW: begin
					if (pos_ok_q) begin
						res_q <= rd_tile;
					end else begin
						status_q <= STAT_NONE;
					end
					st_q <= ST_OUT;
				end
				ST_SCAN: begin
					if (pend_q && hit) begin
						hit_q     <= pa_q;
						res_q     <= rd_tile;
						bbox_q    <= box_out;
						pend_q    <= 1'b0;
						removed_q <= ((cmd_q == CMD_REMOVE_ALL) || (cmd_q == CMD_MERGE)) ?
							CW'(1) : '0;
						rd_q      <= CW'(pa_q) + CW'(1);
						wr_q      <= CW'(pa_q);
						st_q      <= (cmd_q == CMD_HIGHLIGHT) ? ST_FINAL : ST_COMPACT;
					end else if (rd_more) begin
						pend_q <= 1'b1;
						pa_q   <= rd_q[IW-1:0];
						rd_q   <= rd_q + CW'(1);
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						status_q <= STAT_MISS;
						st_q     <= ST_OUT;
					end
				end
				ST_COMPACT: begin
					if (drop) begin
						removed_q <= removed_q + CW'(1);
						bbox_q    <= box_out;
					end else if (pend_q) begin
						wr_q <= wr_q + CW'(1);
					end
					if (rd_more) begin
						pend_q <= 1'b1;
						pa_q   <= rd_q[IW-1:0];
						rd_q   <= rd_q + CW'(1);
					end else begin
						pend_q <= 1'b0;
					end
					if (!pend_q && !rd_more) begin
						count_q <= wr_q;
						i_q     <= wr_q;
						case (cmd_q)
							CMD_RAISE: st_q <= ST_SHIFT;
							CMD_LOWER: st_q <= ST_FINAL;
							CMD_MERGE: begin
								res_q <= merged;
								st_q  <= ST_SHIFT;
							end
							default: st_q <= ST_OUT;
						endcase
					end
				end
				ST_SHIFT: begin
					if (i_q != '0) begin
						pend_q <= 1'b1;
						pa_q   <= IW'(i_q - CW'(1));
						i_q    <= i_q - CW'(1);
					end else begin
						pend_q <= 1'b0;
					end
					if (!pend_q && i_q == '0) begin
						st_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (cmd_q == CMD_HIGHLIGHT) begin
						res_q.c <= hl_q;
					end else begin
						count_q <= count_q + CW'(1);
					end
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tuser <= status_q;
			m_axis_tdata <= {6'd0, 5'(count_q), res_q.c, res_q.h, res_q.w,
				res_q.y, res_q.x, 5'(removed_q)};
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TILES))
		else $error("tile count above capacity");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_COMPACT) |-> (wr_q < rd_q))
		else $error("compaction write index caught up with read index");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT && status_q == STAT_FULL) |-> (count_q == CW'(MAX_TILES)))
		else $error("full status with free entries");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE && $past(st_q) == ST_OUT) |-> !pend_q)
		else $error("read pending after command end");
`endif

endmodule
